>>> sv/lsa_pkg.sv
package lsa_pkg;

  // Widths fixed by the register and field definitions.
  localparam int FIELD_W   = 63;
  localparam int COUNT_W   = 64;
  localparam int CFG_IDX_W = 2;

  // Default generator state width.
  localparam int STATE_BITS_DEF = 63;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 2'd1;

  // Register values after reset.
  localparam logic [FIELD_W-1:0] MULTIPLIER_RST = 63'd1;
  localparam logic [FIELD_W-1:0] INCREMENT_RST  = 63'd0;

endpackage

>>> sv/lsa_mulacc.sv
module lsa_mulacc #(
  parameter int W = lsa_pkg::STATE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] res
);
  import lsa_pkg::*;

  // Computes (a*b + d) mod 2^W with one half-width multiplier: low*low on
  // the start cycle, then high*low and low*high, both of which only
  // contribute their low bits above the split point.
  localparam int HALF = (W + 1) / 2;
  localparam int HI_W = W - HALF;

  logic [W-1:0]      a_r;
  logic [W-1:0]      b_r;
  logic [W-1:0]      acc_r;
  logic [W-1:0]      acc_nxt;
  logic              busy_r;
  logic              step_r;
  logic              done_r;
  logic [HALF-1:0]   mul_x;
  logic [HALF-1:0]   mul_y;
  logic [2*HALF-1:0] prod;
  logic [W-1:0]      term;

  always_comb begin
    if (start) begin
      mul_x = a[HALF-1:0];
      mul_y = b[HALF-1:0];
    end else if (step_r) begin
      mul_x = a_r[HALF-1:0];
      mul_y = HALF'(b_r[W-1:HALF]);
    end else begin
      mul_x = HALF'(a_r[W-1:HALF]);
      mul_y = b_r[HALF-1:0];
    end
  end

  assign prod = (2*HALF)'(mul_x) * (2*HALF)'(mul_y);

  always_comb begin
    if (start) begin
      term    = W'(prod);
      acc_nxt = term + d;
    end else begin
      term    = {prod[HI_W-1:0], {HALF{1'b0}}};
      acc_nxt = acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (start || busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && step_r;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 1'b0;
      end else if (busy_r) begin
        step_r <= ~step_r;
        if (step_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

>>> sv/lcg_skip_ahead.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------
// in       | in_valid / in_ready   | in_skip_count (64, signed),
//          |                       | in_start_seed (63)
// out      | out_valid / out_ready | out_new_seed (63)
// cfg      | cfg_we (no wait)      | cfg_index (2), cfg_data (63)
//
// For every count bit below its highest set bit an item updates the increment
// and the multiplier, for every set bit it updates both accumulators, and it
// ends with the final seed update; a zero count needs only the seed update.
// Every modular multiply goes through the one shared half-width multiplier.
// Reset is synchronous and active low; it loads multiplier 1 and increment 0.
// A finished beat waits in the output register, and the next input beat is
// taken while it waits; a stalled output holds the last multiply until free.
module lcg_skip_ahead #(
  parameter int STATE_BITS = lsa_pkg::STATE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [lsa_pkg::COUNT_W-1:0] in_skip_count,
  input  logic [lsa_pkg::FIELD_W-1:0]     in_start_seed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lsa_pkg::FIELD_W-1:0]     out_new_seed,
  input  logic                            cfg_we,
  input  logic [lsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsa_pkg::FIELD_W-1:0]     cfg_data
);
  import lsa_pkg::*;

  localparam int W = STATE_BITS;

  // Sequencer states. Each multiply state issues one operation to the shared
  // unit and waits for its result.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACCM = 3'd1; // acc_m = acc_m * m
  localparam logic [2:0] ST_ACCC = 3'd2; // acc_c = acc_c * m + c
  localparam logic [2:0] ST_INCR = 3'd3; // c = m * c + c
  localparam logic [2:0] ST_MULT = 3'd4; // m = m * m
  localparam logic [2:0] ST_SEED = 3'd5; // result = acc_m * seed + acc_c
  localparam logic [2:0] ST_OUT  = 3'd6; // wait for the output register

  logic [FIELD_W-1:0] mult_cfg_r;
  logic [FIELD_W-1:0] incr_cfg_r;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic               start_r;
  logic               start_nxt;
  logic [W-1:0]       cnt_r;
  logic [W-1:0]       seed_r;
  logic [W-1:0]       m_r;
  logic [W-1:0]       c_r;
  logic [W-1:0]       accm_r;
  logic [W-1:0]       accc_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_seed_r;

  logic               in_acc;
  logic               out_free;
  logic [W-1:0]       cnt_in;
  logic [W-1:0]       op_a;
  logic [W-1:0]       op_b;
  logic [W-1:0]       op_d;
  logic               mul_done;
  logic [W-1:0]       mul_res;

  // Configuration registers. Writes to an index outside the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_cfg_r <= MULTIPLIER_RST;
      incr_cfg_r <= INCREMENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULTIPLIER: mult_cfg_r <= cfg_data;
        REG_INCREMENT:  incr_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // The count is taken modulo 2^W, so a negative count keeps its low bits.
  assign cnt_in = in_skip_count[W-1:0];

  // Operand selection for the shared unit, following the state that the
  // operation belongs to. Operands are sampled on the start cycle.
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_d = '0;
    case (state_r)
      ST_ACCM: begin
        op_a = accm_r;
        op_b = m_r;
      end
      ST_ACCC: begin
        op_a = accc_r;
        op_b = m_r;
        op_d = c_r;
      end
      ST_INCR: begin
        op_a = m_r;
        op_b = c_r;
        op_d = c_r;
      end
      ST_MULT: begin
        op_a = m_r;
        op_b = m_r;
      end
      ST_SEED: begin
        op_a = accm_r;
        op_b = seed_r;
        op_d = accc_r;
      end
      default: ;
    endcase
  end

  lsa_mulacc #(
    .W (W)
  ) u_mulacc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .a     (op_a),
    .b     (op_b),
    .d     (op_d),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Bits are scanned from the lowest up. After the last set bit the stride
  // pair no longer matters, so the scan stops as soon as the remaining count
  // is zero and goes straight to the seed update.
  always_comb begin
    state_nxt = state_r;
    start_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          start_nxt = 1'b1;
          if (cnt_in == '0) begin
            state_nxt = ST_SEED;
          end else if (cnt_in[0]) begin
            state_nxt = ST_ACCM;
          end else begin
            state_nxt = ST_INCR;
          end
        end
      end
      ST_ACCM: begin
        if (mul_done) begin
          state_nxt = ST_ACCC;
          start_nxt = 1'b1;
        end
      end
      ST_ACCC: begin
        if (mul_done) begin
          start_nxt = 1'b1;
          if (cnt_r[W-1:1] == '0) begin
            state_nxt = ST_SEED;
          end else begin
            state_nxt = ST_INCR;
          end
        end
      end
      ST_INCR: begin
        if (mul_done) begin
          state_nxt = ST_MULT;
          start_nxt = 1'b1;
        end
      end
      ST_MULT: begin
        if (mul_done) begin
          start_nxt = 1'b1;
          // The remaining count is nonzero here, so the next bit exists.
          if (cnt_r[1]) begin
            state_nxt = ST_ACCM;
          end else begin
            state_nxt = ST_INCR;
          end
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  // Working registers. Each result is written back in place; the order of
  // operations within one bit keeps every operand at its value from before
  // that bit.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r  <= cnt_in;
      seed_r <= W'({1'b0, in_start_seed});
      m_r    <= W'({1'b0, mult_cfg_r});
      c_r    <= W'({1'b0, incr_cfg_r});
      accm_r <= W'(1);
      accc_r <= '0;
    end else if (mul_done) begin
      case (state_r)
        ST_ACCM: accm_r <= mul_res;
        ST_ACCC: accc_r <= mul_res;
        ST_INCR: c_r    <= mul_res;
        ST_MULT: begin
          m_r   <= mul_res;
          cnt_r <= cnt_r >> 1;
        end
        default: ;
      endcase
    end
  end

  // Output register. The final product stays in the shared unit until the
  // register is free to take it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_seed_r <= FIELD_W'(64'(mul_res));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_new_seed = out_seed_r;

endmodule

>>> sv/lsa_checker.sv
module lsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lsa_pkg::FIELD_W-1:0] out_new_seed
);
  import lsa_pkg::*;

  // Beats taken in but not yet delivered: one in work plus one waiting.
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + 2'((in_valid && in_ready) ? 1 : 0)
                       - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_seed))
    else $error("output beat changed before it was taken");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two beats outstanding");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && pend_r == 2'd0))
    else $error("output beat without an accepted input");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left output valid or input blocked");

endmodule

bind lcg_skip_ahead lsa_checker u_lsa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_new_seed (out_new_seed)
);
